FILE: hw/rtl/w256_pkg.sv
// ----------------------------------------------------------------------------
// w256_pkg
// Shared types and constants for the 256-bit word ALU: operation codes,
// field widths and the operand and result structures.
// ----------------------------------------------------------------------------
`default_nettype none

package w256_pkg;

    localparam int WORD_W  = 64;
    localparam int WORDS   = 4;
    localparam int DATA_W  = WORD_W * WORDS;
    localparam int MODE_W  = 4;
    localparam int SHIFT_W = 9;
    // Bits of the shift distance that select a position inside the word.
    localparam int SHPOS_W = $clog2(DATA_W);

    typedef enum logic [MODE_W-1:0] {
        MODE_LT     = 4'd0,
        MODE_GT     = 4'd1,
        MODE_EQ     = 4'd2,
        MODE_SLT    = 4'd3,
        MODE_SGT    = 4'd4,
        MODE_ISZERO = 4'd5,
        MODE_NOT    = 4'd6,
        MODE_AND    = 4'd7,
        MODE_OR     = 4'd8,
        MODE_XOR    = 4'd9,
        MODE_SHL    = 4'd10,
        MODE_SHR    = 4'd11,
        MODE_ADD    = 4'd12
    } t_mode;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [DATA_W-1:0]  a;
        logic [DATA_W-1:0]  b;
        logic [SHIFT_W-1:0] shamt;
    } t_op;

    typedef struct packed {
        logic [DATA_W-1:0] word;
        logic              cmp_true;
    } t_res;

endpackage

`default_nettype wire

FILE: hw/rtl/w256_if.sv
// ----------------------------------------------------------------------------
// w256 channel interfaces
// Valid/ready channels for operand items going in and result items coming
// out of the 256-bit word ALU.
// ----------------------------------------------------------------------------
`default_nettype none

interface w256_in_if import w256_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [WORD_W-1:0]  a_w3;
    logic [WORD_W-1:0]  a_w2;
    logic [WORD_W-1:0]  a_w1;
    logic [WORD_W-1:0]  a_w0;
    logic [WORD_W-1:0]  b_w3;
    logic [WORD_W-1:0]  b_w2;
    logic [WORD_W-1:0]  b_w1;
    logic [WORD_W-1:0]  b_w0;
    logic [SHIFT_W-1:0] shift_amount;

    modport source (
        output valid, mode, a_w3, a_w2, a_w1, a_w0,
        output b_w3, b_w2, b_w1, b_w0, shift_amount,
        input  ready
    );
    modport sink (
        input  valid, mode, a_w3, a_w2, a_w1, a_w0,
        input  b_w3, b_w2, b_w1, b_w0, shift_amount,
        output ready
    );
endinterface

interface w256_out_if import w256_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] r_w3;
    logic [WORD_W-1:0] r_w2;
    logic [WORD_W-1:0] r_w1;
    logic [WORD_W-1:0] r_w0;
    logic              cmp_true;

    modport source (
        output valid, r_w3, r_w2, r_w1, r_w0, cmp_true,
        input  ready
    );
    modport sink (
        input  valid, r_w3, r_w2, r_w1, r_w0, cmp_true,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/word256_alu_core.sv
// ----------------------------------------------------------------------------
// word256_alu_core
// 256-bit word ALU: unsigned and signed compares, equality, zero test,
// bitwise not/and/or/xor, logical shifts and addition modulo 2^256.
// Pipeline: an accepted item passes through the input register, then the
// result register, which drives the output channel.
// Throughput: one item per cycle, limited only by the output handshake.
// Reset: synchronous, active low; it clears both stage valid flags only.
// ----------------------------------------------------------------------------
`default_nettype none

module word256_alu_core import w256_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    w256_in_if.sink      i_in,
    w256_out_if.source   o_out
);

    // Stage one holds the captured operands; the evaluation logic sits
    // between it and the result register, which drives the output channel.
    logic r_s1_valid;
    t_op  r_s1_op;
    logic r_out_valid;
    t_res r_res;

    t_res n_res;
    logic out_free;
    logic s1_adv;
    logic in_ready;
    t_op  in_op;

    // The result register can take a new value when it is empty or its
    // item leaves in this cycle; stage one then moves forward, and the
    // input side accepts whenever stage one is empty or moving. This keeps
    // a full pipeline streaming one item per cycle while the output is ready.
    assign out_free = !r_out_valid || o_out.ready;
    assign s1_adv   = r_s1_valid && out_free;
    assign in_ready = !r_s1_valid || out_free;

    assign i_in.ready = in_ready;

    assign in_op.mode  = i_in.mode;
    assign in_op.a     = {i_in.a_w3, i_in.a_w2, i_in.a_w1, i_in.a_w0};
    assign in_op.b     = {i_in.b_w3, i_in.b_w2, i_in.b_w1, i_in.b_w0};
    assign in_op.shamt = i_in.shift_amount;

    w256_exec u_exec (
        .i_op  (r_s1_op),
        .o_res (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Payload registers load only on a move and need no reset.
    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_s1_op <= in_op;
        end
        if (s1_adv) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.r_w3     = r_res.word[4*WORD_W-1:3*WORD_W];
    assign o_out.r_w2     = r_res.word[3*WORD_W-1:2*WORD_W];
    assign o_out.r_w1     = r_res.word[2*WORD_W-1:WORD_W];
    assign o_out.r_w0     = r_res.word[WORD_W-1:0];
    assign o_out.cmp_true = r_res.cmp_true;

`ifndef SYNTH
    // A compare answer never comes with a nonzero result word.
    a_cmp_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.cmp_true) |-> (r_res.word == '0))
        else $error("compare result carries nonzero word");

    // A stalled item in stage one keeps its operands.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_free) |=> (r_s1_valid && $stable(r_s1_op)))
        else $error("stage one item changed while stalled");

    // Input is held off only while both stages are occupied.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> (r_s1_valid && r_out_valid))
        else $error("input stalled with a free stage");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/w256_shift.sv
// ----------------------------------------------------------------------------
// w256_shift
// Logarithmic barrel shifter giving both the logical left and the logical
// right shift of a 256-bit operand; distances past the word give zero.
// ----------------------------------------------------------------------------
`default_nettype none

module w256_shift import w256_pkg::*; (
    input  wire logic [DATA_W-1:0]  i_data,
    input  wire logic [SHIFT_W-1:0] i_shamt,
    output logic      [DATA_W-1:0]  o_shl,
    output logic      [DATA_W-1:0]  o_shr
);

    logic [DATA_W-1:0] left_v;
    logic [DATA_W-1:0] right_v;
    logic              overflow;

    // Any bit above the position field means the whole word shifts out.
    assign overflow = |i_shamt[SHIFT_W-1:SHPOS_W];

    always_comb begin
        left_v  = i_data;
        right_v = i_data;
        for (int k = 0; k < SHPOS_W; k++) begin
            if (i_shamt[k]) begin
                left_v  = left_v << (1 << k);
                right_v = right_v >> (1 << k);
            end
        end
        o_shl = overflow ? '0 : left_v;
        o_shr = overflow ? '0 : right_v;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/w256_exec.sv
// ----------------------------------------------------------------------------
// w256_exec
// Single-pass evaluation of one operation: compares, bitwise logic, shifts
// and the 256-bit sum, selected by the operation code.
// ----------------------------------------------------------------------------
`default_nettype none

module w256_exec import w256_pkg::*; (
    input  wire t_op  i_op,
    output t_res      o_res
);

    logic [DATA_W-1:0] shl_v;
    logic [DATA_W-1:0] shr_v;
    logic [DATA_W-1:0] sum_v;
    logic              u_lt;
    logic              u_gt;
    logic              s_lt;
    logic              s_gt;
    logic              sign_diff;

    w256_shift u_shift (
        .i_data  (i_op.a),
        .i_shamt (i_op.shamt),
        .o_shl   (shl_v),
        .o_shr   (shr_v)
    );

    assign sum_v     = i_op.a + i_op.b;
    assign u_lt      = i_op.a < i_op.b;
    assign u_gt      = i_op.b < i_op.a;
    // With differing signs the negative operand is the smaller one.
    assign sign_diff = i_op.a[DATA_W-1] ^ i_op.b[DATA_W-1];
    assign s_lt      = sign_diff ? i_op.a[DATA_W-1] : u_lt;
    assign s_gt      = sign_diff ? i_op.b[DATA_W-1] : u_gt;

    always_comb begin
        o_res = '0;
        case (t_mode'(i_op.mode))
            MODE_LT:     o_res.cmp_true = u_lt;
            MODE_GT:     o_res.cmp_true = u_gt;
            MODE_EQ:     o_res.cmp_true = (i_op.a == i_op.b);
            MODE_SLT:    o_res.cmp_true = s_lt;
            MODE_SGT:    o_res.cmp_true = s_gt;
            MODE_ISZERO: o_res.cmp_true = ~|i_op.a;
            MODE_NOT:    o_res.word = ~i_op.a;
            MODE_AND:    o_res.word = i_op.a & i_op.b;
            MODE_OR:     o_res.word = i_op.a | i_op.b;
            MODE_XOR:    o_res.word = i_op.a ^ i_op.b;
            MODE_SHL:    o_res.word = shl_v;
            MODE_SHR:    o_res.word = shr_v;
            MODE_ADD:    o_res.word = sum_v;
            default:     o_res = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: test/word256_alu_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// word256_alu_core_test
// Self-checking bench for the 256-bit word ALU. A queue of operand items
// (directed corner cases, then random traffic) is driven in bursts with random
// gaps, while the result side stalls on rotating ready patterns. Every
// accepted item is run through a local model of the ALU, and each result
// item is checked word by word against the oldest prediction.
// ----------------------------------------------------------------------------

module word256_alu_core_test import w256_pkg::*; ();

    localparam int ITEM_COUNT  = 1700;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 8;

    localparam logic [DATA_W-1:0] ALL_ONES  = '1;
    localparam logic [DATA_W-1:0] SIGN_BIT  = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] MAX_POS   = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] LSB_ONE   = {{(DATA_W-1){1'b0}}, 1'b1};
    localparam logic [DATA_W-1:0] CHECKER   = {(DATA_W/2){2'b01}};
    localparam logic [DATA_W-1:0] WORD0_MAX = {{(DATA_W-WORD_W){1'b0}}, {WORD_W{1'b1}}};
    localparam int MODE_TOP = (1 << MODE_W) - 1;
    localparam int SHAMT_TOP = (1 << SHIFT_W) - 1;

    logic clk;
    logic rst_n;

    w256_in_if  in_ch ();
    w256_out_if out_ch ();

    word256_alu_core u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_op  op_backlog[$];
    t_res want_results[$];

    int   err_cnt    = 0;
    int   cycle_cnt  = 0;
    int   queued_cnt = 0;
    int   taken_cnt  = 0;
    int   burst_left = 0;
    int   gap_left   = 0;
    logic in_fire    = 1'b0;
    logic [7:0] ready_pat = 8'hFF;

    t_op  next_op;
    t_op  seen_op;
    t_res got_res;
    t_res want_res;

    logic [MODE_W-1:0]  pick_mode;
    logic [DATA_W-1:0]  pick_a;
    logic [DATA_W-1:0]  pick_b;
    logic [SHIFT_W-1:0] pick_sh;

    // Expected result of one operand item.
    function automatic t_res calc_alu_result(input t_op op);
        t_res res;
        res = '0;
        case (op.mode)
            MODE_LT:     res.cmp_true = (op.a < op.b);
            MODE_GT:     res.cmp_true = (op.a > op.b);
            MODE_EQ:     res.cmp_true = (op.a == op.b);
            MODE_SLT:    res.cmp_true = ($signed(op.a) < $signed(op.b));
            MODE_SGT:    res.cmp_true = ($signed(op.a) > $signed(op.b));
            MODE_ISZERO: res.cmp_true = (op.a == '0);
            MODE_NOT:    res.word = ~op.a;
            MODE_AND:    res.word = op.a & op.b;
            MODE_OR:     res.word = op.a | op.b;
            MODE_XOR:    res.word = op.a ^ op.b;
            MODE_SHL:    if (op.shamt < DATA_W) res.word = op.a << op.shamt;
            MODE_SHR:    if (op.shamt < DATA_W) res.word = op.a >> op.shamt;
            MODE_ADD:    res.word = op.a + op.b;
            default:     res = '0;
        endcase
        return res;
    endfunction

    task automatic queue_op(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] a,
                            input logic [DATA_W-1:0] b, input logic [SHIFT_W-1:0] sh);
        t_op op;
        op.mode  = mode;
        op.a     = a;
        op.b     = b;
        op.shamt = sh;
        op_backlog.push_back(op);
        queued_cnt++;
    endtask

    // Random operand, biased toward values that sit on boundaries.
    function automatic logic [DATA_W-1:0] rand_operand();
        logic [DATA_W-1:0] v;
        for (int w = 0; w < WORDS; w++) v[w*WORD_W +: WORD_W] = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = ALL_ONES;
            2: v = SIGN_BIT;
            3: v = MAX_POS;
            4: v = LSB_ONE << $urandom_range(0, DATA_W - 1);
            5: v[$urandom_range(0, WORDS - 1)*WORD_W +: WORD_W] = '1;
            6: v = v >> $urandom_range(0, DATA_W - 1);
            default: ;
        endcase
        return v;
    endfunction

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Source side: items leave the backlog in bursts separated by idle gaps.
    always @(negedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_fire) begin
            if (gap_left > 0 || op_backlog.size() == 0) begin
                in_ch.valid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
                next_op = op_backlog.pop_front();
                in_ch.valid        <= 1'b1;
                in_ch.mode         <= next_op.mode;
                in_ch.a_w3         <= next_op.a[3*WORD_W +: WORD_W];
                in_ch.a_w2         <= next_op.a[2*WORD_W +: WORD_W];
                in_ch.a_w1         <= next_op.a[1*WORD_W +: WORD_W];
                in_ch.a_w0         <= next_op.a[0 +: WORD_W];
                in_ch.b_w3         <= next_op.b[3*WORD_W +: WORD_W];
                in_ch.b_w2         <= next_op.b[2*WORD_W +: WORD_W];
                in_ch.b_w1         <= next_op.b[1*WORD_W +: WORD_W];
                in_ch.b_w0         <= next_op.b[0 +: WORD_W];
                in_ch.shift_amount <= next_op.shamt;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Sink side: ready follows an 8-bit pattern that rotates every cycle and
    // is replaced at times set by the cycle counter; at least a quarter of the patterns never stall.
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (cycle_cnt % 64 == 0) begin
                ready_pat <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
            end else begin
                ready_pat <= {ready_pat[6:0], ready_pat[7]};
            end
            out_ch.ready <= ready_pat[0];
        end
    end

    // Both handshakes are observed at the rising edge.
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        in_fire   <= rst_n && in_ch.valid && in_ch.ready;

        if (rst_n && in_ch.valid && in_ch.ready) begin
            seen_op.mode  = in_ch.mode;
            seen_op.a     = {in_ch.a_w3, in_ch.a_w2, in_ch.a_w1, in_ch.a_w0};
            seen_op.b     = {in_ch.b_w3, in_ch.b_w2, in_ch.b_w1, in_ch.b_w0};
            seen_op.shamt = in_ch.shift_amount;
            want_results.push_back(calc_alu_result(seen_op));
            taken_cnt <= taken_cnt + 1;
        end

        if (rst_n && out_ch.valid && out_ch.ready) begin
            got_res.word     = {out_ch.r_w3, out_ch.r_w2, out_ch.r_w1, out_ch.r_w0};
            got_res.cmp_true = out_ch.cmp_true;
            if (want_results.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected result item, expected none, got %h cmp %b",
                         $time, got_res.word, got_res.cmp_true);
            end else begin
                want_res = want_results.pop_front();
                for (int w = WORDS - 1; w >= 0; w--) begin
                    if (got_res.word[w*WORD_W +: WORD_W] !== want_res.word[w*WORD_W +: WORD_W]) begin
                        err_cnt++;
                        $display("%0t: r_w%0d expected %h, actual %h", $time, w,
                                 want_res.word[w*WORD_W +: WORD_W],
                                 got_res.word[w*WORD_W +: WORD_W]);
                    end
                end
                if (got_res.cmp_true !== want_res.cmp_true) begin
                    err_cnt++;
                    $display("%0t: cmp_true expected %b, actual %b", $time,
                             want_res.cmp_true, got_res.cmp_true);
                end
            end
        end

        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("FAIL word256_alu_core");
            $finish;
        end
    end

    initial begin
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.mode         = '0;
        in_ch.a_w3         = '0;
        in_ch.a_w2         = '0;
        in_ch.a_w1         = '0;
        in_ch.a_w0         = '0;
        in_ch.b_w3         = '0;
        in_ch.b_w2         = '0;
        in_ch.b_w1         = '0;
        in_ch.b_w0         = '0;
        in_ch.shift_amount = '0;
        out_ch.ready       = 1'b0;

        // Directed corners: field extremes, every operation, signed compares
        // with equal and differing signs, shifts on word boundaries and out of
        // range, the dropped carry of add, and the unused mode codes.
        queue_op(MODE_LT, '0, ALL_ONES, '0);
        queue_op(MODE_GT, ALL_ONES, '0, '1);
        queue_op(MODE_EQ, ALL_ONES, ALL_ONES, '0);
        queue_op(MODE_EQ, ALL_ONES, ALL_ONES ^ LSB_ONE, '0);
        queue_op(MODE_SLT, SIGN_BIT, MAX_POS, '0);
        queue_op(MODE_SGT, SIGN_BIT, MAX_POS, '0);
        queue_op(MODE_SLT, ALL_ONES, SIGN_BIT, '0);
        queue_op(MODE_SGT, MAX_POS, MAX_POS, '0);
        queue_op(MODE_ISZERO, '0, ALL_ONES, '0);
        queue_op(MODE_ISZERO, SIGN_BIT, '0, '0);
        queue_op(MODE_NOT, '0, ALL_ONES, '0);
        queue_op(MODE_AND, ALL_ONES, CHECKER, '0);
        queue_op(MODE_OR, CHECKER, ~CHECKER, '0);
        queue_op(MODE_XOR, ALL_ONES, CHECKER, '0);
        queue_op(MODE_SHL, CHECKER, ALL_ONES, '0);
        queue_op(MODE_SHL, LSB_ONE, '0, SHIFT_W'(DATA_W - 1));
        queue_op(MODE_SHL, ALL_ONES, '0, SHIFT_W'(DATA_W));
        queue_op(MODE_SHR, ALL_ONES, '0, '1);
        queue_op(MODE_SHR, ALL_ONES, '0, SHIFT_W'(WORD_W));
        queue_op(MODE_SHR, SIGN_BIT | LSB_ONE, '0, SHIFT_W'(1));
        queue_op(MODE_ADD, ALL_ONES, LSB_ONE, '0);
        queue_op(MODE_ADD, WORD0_MAX, LSB_ONE, '0);
        for (int m = MODE_ADD + 1; m <= MODE_TOP; m++)
            queue_op(MODE_W'(m), ALL_ONES, ALL_ONES, '1);

        // Random traffic; b is often tied to a so compares reach the low words.
        for (int n = 0; n < ITEM_COUNT; n++) begin
            if ($urandom_range(0, 15) == 0)
                pick_mode = MODE_W'($urandom_range(MODE_ADD + 1, MODE_TOP));
            else
                pick_mode = MODE_W'($urandom_range(MODE_LT, MODE_ADD));
            pick_a = rand_operand();
            case ($urandom_range(0, 4))
                0: pick_b = pick_a;
                1: begin
                    pick_b = pick_a;
                    pick_b[$urandom_range(0, WORDS - 1)*WORD_W +: WORD_W] = {$urandom, $urandom};
                end
                2: pick_b = pick_a ^ (LSB_ONE << $urandom_range(0, DATA_W - 1));
                default: pick_b = rand_operand();
            endcase
            case ($urandom_range(0, 3))
                0: pick_sh = SHIFT_W'($urandom_range(0, SHAMT_TOP));
                1: pick_sh = SHIFT_W'($urandom_range(0, WORDS) * WORD_W + $urandom_range(0, 1));
                default: pick_sh = SHIFT_W'($urandom_range(0, DATA_W));
            endcase
            queue_op(pick_mode, pick_a, pick_b, pick_sh);
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (taken_cnt != queued_cnt || want_results.size() != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        if (err_cnt == 0) begin
            $display("PASS word256_alu_core");
        end else begin
            $display("FAIL word256_alu_core");
        end
        $finish;
    end

endmodule
